/* rtl/chmh_pkg.sv */
package chmh_pkg;

  // Key layout, most significant first: cost, position, progress, direction.
  localparam int unsigned CostW   = 16;
  localparam int unsigned PosW    = 8;
  localparam int unsigned ProgW   = 16;
  localparam int unsigned DirW    = 3;
  localparam int unsigned DirLsb  = 0;
  localparam int unsigned ProgLsb = DirLsb + DirW;
  localparam int unsigned PosLsb  = ProgLsb + ProgW;
  localparam int unsigned CostLsb = PosLsb + PosW;
  localparam int unsigned KeyW    = CostLsb + CostW;

  // Payload layout: parent link, box, task.
  localparam int unsigned LinkW   = 16;
  localparam int unsigned BoxW    = 8;
  localparam int unsigned TaskW   = 8;
  localparam int unsigned TaskLsb = 0;
  localparam int unsigned BoxLsb  = TaskLsb + TaskW;
  localparam int unsigned LinkLsb = BoxLsb + BoxW;
  localparam int unsigned PayW    = LinkLsb + LinkW;

  localparam int unsigned OccW     = 12;
  localparam int unsigned AddrMaxW = 16;

  typedef enum logic [1:0] {
    FuncPush  = 2'd0,
    FuncPop   = 2'd1,
    FuncClear = 2'd2,
    FuncNop   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StPushCmp,
    StPushWr,
    StPopLoad,
    StPopCmp,
    StPopWr,
    StDone
  } ctrl_state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [PayW-1:0] pay;
  } node_t;

  typedef struct packed {
    logic                we;
    logic [AddrMaxW-1:0] waddr;
    node_t               wdata;
    logic                re;
    logic [AddrMaxW-1:0] raddr_a;
    logic [AddrMaxW-1:0] raddr_b;
  } ram_req_t;

  typedef struct packed {
    status_e         status;
    node_t           node;
    logic [OccW-1:0] occupancy;
  } result_t;

endpackage

/* rtl/composite_key_min_heap.sv */
// Channel  Handshake              Beat contents
// -------  ---------------------  ------------------------------------------------
// input    in_valid_i/in_stall_o  func_i, cost_i, pos_index_i, progress_packed_i,
//                                 last_direction_i, parent_link_i, box_number_i,
//                                 task_number_i
// output   out_valid_o/out_stall_i status_o, out_cost_o, out_pos_index_o,
//                                 out_progress_o, out_last_direction_o,
//                                 out_parent_link_o, out_box_number_o,
//                                 out_task_number_o, occupancy_o
//
// One beat is worked on at a time. A push into a non-empty heap reads the parent
// of the new slot and moves parents down one level at a time until the node fits;
// a pop reads the root and the last node, then moves the smaller child up one
// level at a time while the last node sinks, unless it took the only node held.
// Clear, a full push or an empty pop go straight to the result. The sift loop does
// one read, compare and write back through the node memory per heap level.
// Reset clears the count and the control state only; the node memory is not
// cleared, since a slot at or above the count may be read but is never used.
// The result sits in an output register, so the next beat is taken while the
// previous result is stalled; the engine holds its finished result until that
// register frees up.
module composite_key_min_heap #(
  parameter int unsigned HEAP_DEPTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] cost_i,
  input  logic [7:0]  pos_index_i,
  input  logic [15:0] progress_packed_i,
  input  logic [2:0]  last_direction_i,
  input  logic [15:0] parent_link_i,
  input  logic [7:0]  box_number_i,
  input  logic [7:0]  task_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_cost_o,
  output logic [7:0]  out_pos_index_o,
  output logic [15:0] out_progress_o,
  output logic [2:0]  out_last_direction_o,
  output logic [15:0] out_parent_link_o,
  output logic [7:0]  out_box_number_o,
  output logic [7:0]  out_task_number_o,
  output logic [11:0] occupancy_o
);

  chmh_pkg::node_t    node_in;
  chmh_pkg::ram_req_t ram_req;
  chmh_pkg::node_t    rd_a;
  chmh_pkg::node_t    rd_b;
  chmh_pkg::result_t  res;
  chmh_pkg::result_t  res_q;
  logic               res_valid;
  logic               res_ready;
  logic               out_valid_q;

  // The key fields concatenate so that one unsigned compare orders them
  // by cost, then position, then progress, then direction.
  assign node_in.key = {cost_i, pos_index_i, progress_packed_i, last_direction_i};
  assign node_in.pay = {parent_link_i, box_number_i, task_number_i};

  chmh_ctrl #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .node_i     (node_in),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .ram_req_o  (ram_req),
    .rd_a_i     (rd_a),
    .rd_b_i     (rd_b)
  );

  chmh_ram #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) u_ram (
    .clk_i (clk_i),
    .req_i (ram_req),
    .rd_a_o(rd_a),
    .rd_b_o(rd_b)
  );

  // Output register: loads when empty or when its beat leaves this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = res_q.status;
  assign out_cost_o           = res_q.node.key[chmh_pkg::CostLsb +: chmh_pkg::CostW];
  assign out_pos_index_o      = res_q.node.key[chmh_pkg::PosLsb +: chmh_pkg::PosW];
  assign out_progress_o       = res_q.node.key[chmh_pkg::ProgLsb +: chmh_pkg::ProgW];
  assign out_last_direction_o = res_q.node.key[chmh_pkg::DirLsb +: chmh_pkg::DirW];
  assign out_parent_link_o    = res_q.node.pay[chmh_pkg::LinkLsb +: chmh_pkg::LinkW];
  assign out_box_number_o     = res_q.node.pay[chmh_pkg::BoxLsb +: chmh_pkg::BoxW];
  assign out_task_number_o    = res_q.node.pay[chmh_pkg::TaskLsb +: chmh_pkg::TaskW];
  assign occupancy_o          = res_q.occupancy;

endmodule

/* rtl/chmh_ram.sv */
// Node storage: one write port and two registered read ports.
module chmh_ram #(
  parameter int unsigned HEAP_DEPTH = 2048
) (
  input  logic                clk_i,
  input  chmh_pkg::ram_req_t  req_i,
  output chmh_pkg::node_t     rd_a_o,
  output chmh_pkg::node_t     rd_b_o
);

  localparam int unsigned IW = $clog2(HEAP_DEPTH);

  chmh_pkg::node_t mem_q [HEAP_DEPTH];
  chmh_pkg::node_t rd_a_q;
  chmh_pkg::node_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[IW-1:0]] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_a_q <= mem_q[req_i.raddr_a[IW-1:0]];
      rd_b_q <= mem_q[req_i.raddr_b[IW-1:0]];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

/* rtl/chmh_ctrl.sv */
// Sift sequencer: walks the heap one level per cycle through the node memory.
module chmh_ctrl #(
  parameter int unsigned HEAP_DEPTH = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  chmh_pkg::node_t    node_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output chmh_pkg::result_t  res_o,
  output chmh_pkg::ram_req_t ram_req_o,
  input  chmh_pkg::node_t    rd_a_i,
  input  chmh_pkg::node_t    rd_b_i
);

  localparam int unsigned IW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned LW = IW + 2;
  localparam int unsigned AW = chmh_pkg::AddrMaxW;

  chmh_pkg::ctrl_state_e state_q, state_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  chmh_pkg::node_t       node_q, node_d;
  chmh_pkg::node_t       onode_q, onode_d;
  chmh_pkg::status_e     status_q, status_d;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_par;
  logic [IW-1:0] idx_par;
  logic [IW-1:0] idx_par_par;
  logic [LW-1:0] l_cur, r_cur, l_nxt;
  logic [IW-1:0] s_idx;
  logic          r_in, lt_rl, lt_lk, lt_rk, lt_nk, sel_r, move_dn;
  logic [31:0]   occ_ext;

  assign cnt_m1      = cnt_q - 1'b1;
  assign cnt_par     = cnt_m1 >> 1;
  assign idx_par     = (idx_q - 1'b1) >> 1;
  assign idx_par_par = (idx_par - 1'b1) >> 1;

  // Children of the hole, and the four key compares done side by side.
  assign l_cur   = {1'b0, idx_q, 1'b1};
  assign r_cur   = l_cur + 1'b1;
  assign r_in    = r_cur < LW'(cnt_q);
  assign lt_rl   = rd_b_i.key < rd_a_i.key;
  assign lt_lk   = rd_a_i.key < node_q.key;
  assign lt_rk   = rd_b_i.key < node_q.key;
  assign lt_nk   = node_q.key < rd_a_i.key;
  assign sel_r   = r_in && lt_rl;
  assign move_dn = sel_r ? lt_rk : lt_lk;
  assign s_idx   = sel_r ? r_cur[IW-1:0] : l_cur[IW-1:0];
  assign l_nxt   = {1'b0, s_idx, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chmh_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    node_q   <= node_d;
    onode_q  <= onode_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    node_d    = node_q;
    onode_d   = onode_q;
    status_d  = status_q;
    ram_req_o = '0;
    unique case (state_q)
      chmh_pkg::StIdle: begin
        if (in_valid_i) begin
          status_d = chmh_pkg::StatOk;
          onode_d  = '0;
          unique case (chmh_pkg::func_e'(func_i))
            chmh_pkg::FuncPush: begin
              if (cnt_q == CW'(HEAP_DEPTH)) begin
                status_d = chmh_pkg::StatFull;
                state_d  = chmh_pkg::StDone;
              end else begin
                node_d = node_i;
                idx_d  = cnt_q[IW-1:0];
                cnt_d  = cnt_q + 1'b1;
                if (cnt_q == '0) begin
                  state_d = chmh_pkg::StPushWr;
                end else begin
                  ram_req_o.re      = 1'b1;
                  ram_req_o.raddr_a = AW'(cnt_par);
                  state_d           = chmh_pkg::StPushCmp;
                end
              end
            end
            chmh_pkg::FuncPop: begin
              if (cnt_q == '0) begin
                status_d = chmh_pkg::StatEmpty;
                state_d  = chmh_pkg::StDone;
              end else begin
                ram_req_o.re      = 1'b1;
                ram_req_o.raddr_a = '0;
                ram_req_o.raddr_b = AW'(cnt_m1);
                cnt_d             = cnt_m1;
                state_d           = chmh_pkg::StPopLoad;
              end
            end
            chmh_pkg::FuncClear: begin
              cnt_d   = '0;
              state_d = chmh_pkg::StDone;
            end
            chmh_pkg::FuncNop: begin
              state_d = chmh_pkg::StDone;
            end
            default: state_d = chmh_pkg::StDone;
          endcase
        end
      end
      chmh_pkg::StPushCmp: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = AW'(idx_q);
        if (lt_nk) begin
          // The parent moves down into the hole; continue one level up.
          ram_req_o.wdata = rd_a_i;
          idx_d           = idx_par;
          if (idx_par == '0) begin
            state_d = chmh_pkg::StPushWr;
          end else begin
            ram_req_o.re      = 1'b1;
            ram_req_o.raddr_a = AW'(idx_par_par);
          end
        end else begin
          ram_req_o.wdata = node_q;
          state_d         = chmh_pkg::StDone;
        end
      end
      chmh_pkg::StPushWr, chmh_pkg::StPopWr: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = AW'(idx_q);
        ram_req_o.wdata = node_q;
        state_d         = chmh_pkg::StDone;
      end
      chmh_pkg::StPopLoad: begin
        onode_d = rd_a_i;
        node_d  = rd_b_i;
        idx_d   = '0;
        if (cnt_q == '0) begin
          state_d = chmh_pkg::StDone;
        end else if (cnt_q > CW'(1)) begin
          ram_req_o.re      = 1'b1;
          ram_req_o.raddr_a = AW'(1);
          ram_req_o.raddr_b = AW'(2);
          state_d           = chmh_pkg::StPopCmp;
        end else begin
          state_d = chmh_pkg::StPopWr;
        end
      end
      chmh_pkg::StPopCmp: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = AW'(idx_q);
        if (move_dn) begin
          // The smaller child moves up into the hole; continue one level down.
          ram_req_o.wdata = sel_r ? rd_b_i : rd_a_i;
          idx_d           = s_idx;
          if (l_nxt < LW'(cnt_q)) begin
            ram_req_o.re      = 1'b1;
            ram_req_o.raddr_a = AW'(l_nxt);
            ram_req_o.raddr_b = AW'(l_nxt + 1'b1);
          end else begin
            state_d = chmh_pkg::StPopWr;
          end
        end else begin
          ram_req_o.wdata = node_q;
          state_d         = chmh_pkg::StDone;
        end
      end
      chmh_pkg::StDone: begin
        if (res_ready_i) begin
          state_d = chmh_pkg::StIdle;
        end
      end
      default: state_d = chmh_pkg::StIdle;
    endcase
  end

  assign occ_ext          = 32'(cnt_q);
  assign res_o.status     = status_q;
  assign res_o.node       = onode_q;
  assign res_o.occupancy  = occ_ext[chmh_pkg::OccW-1:0];
  assign res_valid_o      = (state_q == chmh_pkg::StDone);
  assign in_stall_o       = (state_q != chmh_pkg::StIdle);

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(HEAP_DEPTH))
    else $error("heap count exceeds depth");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> (LW'(ram_req_o.waddr[IW-1:0]) < LW'(cnt_q)))
    else $error("memory write outside occupied slots");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == chmh_pkg::StIdle |-> !ram_req_o.we)
    else $error("memory write while idle");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chmh_pkg::StIdle) && in_valid_i && (func_i == chmh_pkg::FuncPop)
      && (cnt_q != '0)
    |=> cnt_q == ($past(cnt_q) - 1'b1))
    else $error("pop did not remove exactly one node");
`endif

endmodule
